[rtl/cct_pkg.sv]
package cct_pkg;

	localparam int MapLen = 68;
	localparam int OqDepth = 4;
	localparam int OqAw = 2;
	localparam int OqCw = 3;

	localparam logic [7:0] PairLeadCyrA = 8'hD0;
	localparam logic [7:0] PairLeadCyrB = 8'hD1;
	localparam logic [7:0] PairLeadSign = 8'hC2;
	localparam logic [7:0] MinHeld = 8'd32;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		byte_t data;
		logic  last;
	} cct_item_t;

	typedef struct packed {
		logic [1:0] count;
		cct_item_t  first;
		cct_item_t  second;
	} cct_res_t;

	localparam byte_t WinCodes [MapLen] = '{
		8'd169, 8'd174, 8'd184, 8'd224, 8'd225, 8'd226, 8'd227, 8'd228, 8'd229, 8'd230,
		8'd231, 8'd232, 8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd238, 8'd239, 8'd240,
		8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250,
		8'd251, 8'd252, 8'd253, 8'd254, 8'd255,
		8'd168, 8'd192, 8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198, 8'd199, 8'd200,
		8'd201, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208, 8'd209, 8'd210,
		8'd211, 8'd212, 8'd213, 8'd214, 8'd215, 8'd216, 8'd217, 8'd218, 8'd219, 8'd220,
		8'd221, 8'd222, 8'd223
	};

	localparam byte_t KoiCodes [MapLen] = '{
		8'd191, 8'd148, 8'd163, 8'd193, 8'd194, 8'd215, 8'd199, 8'd196, 8'd197, 8'd214,
		8'd218, 8'd201, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208, 8'd210,
		8'd211, 8'd212, 8'd213, 8'd198, 8'd200, 8'd195, 8'd222, 8'd219, 8'd221, 8'd223,
		8'd217, 8'd216, 8'd220, 8'd192, 8'd209,
		8'd179, 8'd225, 8'd226, 8'd247, 8'd231, 8'd228, 8'd229, 8'd246, 8'd250, 8'd233,
		8'd234, 8'd235, 8'd236, 8'd237, 8'd238, 8'd239, 8'd240, 8'd242, 8'd243, 8'd244,
		8'd245, 8'd230, 8'd232, 8'd227, 8'd254, 8'd251, 8'd253, 8'd255, 8'd249, 8'd248,
		8'd252, 8'd224, 8'd241
	};

	// The lowest matching entry wins, so the scan runs from the top down.
	function automatic byte_t win_to_koi(input byte_t b);
		byte_t r;
		r = b;
		for (int i = MapLen - 1; i >= 0; i--) begin
			if (WinCodes[i] == b) r = KoiCodes[i];
		end
		return r;
	endfunction

	function automatic byte_t koi_to_win(input byte_t b);
		byte_t r;
		r = b;
		for (int i = MapLen - 1; i >= 0; i--) begin
			if (KoiCodes[i] == b) r = WinCodes[i];
		end
		return r;
	endfunction

endpackage

[rtl/cyrillic_charset_transcoder.sv]
// Cyrillic byte-stream transcoder.
// Input channel: in_valid/in_ready carry one item, a byte and its in_last flag.
// Output channel: out_valid/out_ready carry one converted byte and out_last.
// cfg_we/cfg_wdata write the direction bit: 0 folds UTF-8 Cyrillic pairs into
// CP1251 and then maps to KOI8-R, 1 maps KOI8-R to CP1251 byte by byte.
// Write the direction only while the block is idle.
// An accepted item is held in the input register and is converted by a single
// combinational pass into zero, one or two results written to a four-entry
// output queue.
// In outbound mode a byte of value 32 or above waits for the next item;
// a byte marked last is never held.
// Throughput is one item per cycle while the queue has room; the output
// queue drains one per cycle. When the receiver stalls, the queue fills and
// in_ready drops once it has fewer than two free entries.
// Reset clears the direction to 0, drops any held byte and empties the queue.
module cyrillic_charset_transcoder import cct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  logic  cfg_wdata,
	input  logic  in_valid,
	output logic  in_ready,
	input  byte_t in_byte,
	input  logic  in_last,
	output logic  out_valid,
	input  logic  out_ready,
	output byte_t out_byte,
	output logic  out_last
);

	logic      v_s1;
	byte_t     byte_s1;
	logic      last_s1;
	logic      room;
	logic      advance;
	cct_res_t  res;
	cct_item_t head;

	assign advance = v_s1 && room;
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	cct_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.advance  (advance),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1),
		.res      (res)
	);

	cct_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.res      (res),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign out_byte = head.data;
	assign out_last = head.last;

endmodule

[rtl/cct_fold.sv]
module cct_fold import cct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  logic     advance,
	input  byte_t    byte_s1,
	input  logic     last_s1,
	output cct_res_t res
);

	logic  dir_q;
	logic  held_valid_q;
	byte_t held_byte_q;
	logic  held_valid_d;
	byte_t held_byte_d;
	logic  pair_ok;
	byte_t pair_cp;
	logic  fresh_hold;
	byte_t fresh_out;

	always_comb begin
		pair_ok = 1'b0;
		pair_cp = byte_s1;
		if (held_byte_q == PairLeadCyrA) begin
			if (byte_s1 >= 8'h90 && byte_s1 <= 8'hBF) begin
				pair_ok = 1'b1;
				pair_cp = byte_s1 + 8'h30;
			end else if (byte_s1 == 8'h81) begin
				pair_ok = 1'b1;
				pair_cp = 8'hA8;
			end
		end else if (held_byte_q == PairLeadCyrB) begin
			if (byte_s1 >= 8'h80 && byte_s1 <= 8'h8F) begin
				pair_ok = 1'b1;
				pair_cp = byte_s1 + 8'h70;
			end else if (byte_s1 == 8'h91) begin
				pair_ok = 1'b1;
				pair_cp = 8'hB8;
			end
		end else if (held_byte_q == PairLeadSign) begin
			if (byte_s1 == 8'hA9 || byte_s1 == 8'hAE) begin
				pair_ok = 1'b1;
			end
		end
	end

	assign fresh_hold = (byte_s1 >= MinHeld) && !last_s1;
	assign fresh_out = dir_q ? koi_to_win(byte_s1) : win_to_koi(byte_s1);

	always_comb begin
		res = '0;
		held_valid_d = 1'b0;
		held_byte_d = held_byte_q;
		if (held_valid_q && (dir_q || !pair_ok)) begin
			res.first = '{data: win_to_koi(held_byte_q), last: 1'b0};
			if (dir_q || !fresh_hold) begin
				res.second = '{data: fresh_out, last: last_s1};
				res.count = 2'd2;
			end else begin
				res.count = 2'd1;
				held_valid_d = 1'b1;
				held_byte_d = byte_s1;
			end
		end else if (held_valid_q) begin
			res.first = '{data: win_to_koi(pair_cp), last: last_s1};
			res.count = 2'd1;
		end else if (dir_q || !fresh_hold) begin
			res.first = '{data: fresh_out, last: last_s1};
			res.count = 2'd1;
		end else begin
			held_valid_d = 1'b1;
			held_byte_d = byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
			held_valid_q <= 1'b0;
			held_byte_q <= '0;
		end else begin
			if (cfg_we) dir_q <= cfg_wdata;
			if (advance) begin
				held_valid_q <= held_valid_d;
				held_byte_q <= held_byte_d;
			end
		end
	end

endmodule

[rtl/cct_outq.sv]
module cct_outq import cct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cct_res_t res,
	output logic     room,
	output logic     out_valid,
	input  logic     out_ready,
	output cct_item_t head
);

	cct_item_t        mem_q [OqDepth];
	logic [OqAw-1:0]  wp_q;
	logic [OqAw-1:0]  rp_q;
	logic [OqCw-1:0]  cnt_q;
	logic             pop;
	logic [1:0]       n;
	logic [OqAw-1:0]  wp_next;

	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign head = mem_q[rp_q];
	assign n = push ? res.count : 2'd0;
	assign wp_next = wp_q + OqAw'(1);
	assign room = (cnt_q <= OqCw'(OqDepth - 2)) ||
		((cnt_q == OqCw'(OqDepth - 1)) && pop);

	always_ff @(posedge clk) begin
		if (n != 2'd0) mem_q[wp_q] <= res.first;
		if (n == 2'd2) mem_q[wp_next] <= res.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + OqAw'(n);
			if (pop) rp_q <= rp_q + OqAw'(1);
			cnt_q <= cnt_q + OqCw'(n) - OqCw'(pop);
		end
	end

endmodule

[rtl/cct_chk.sv]
module cct_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output item changed");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no output backlog");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(in_valid) |=> in_ready)
		else $error("input stalled after idle cycles");

endmodule

bind cyrillic_charset_transcoder cct_chk u_cct_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_byte (out_byte),
	.out_last (out_last)
);
